[src/bpc_pkg.sv]
// Package for the barometer compensation block: sequencer states, register
// indexes, scheme constants and the 24-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  // command / kind codes
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_PRES = 1'b1;

  // output range
  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = -24'sh800000;

  // scheme constants
  localparam logic signed [27:0] B6_OFS    = 28'sd4000;
  localparam logic signed [63:0] X3_OFS    = 64'sd32768;
  localparam logic [16:0]        PRS_SCALE = 17'd50000;
  localparam logic signed [27:0] C_SQ      = 28'sd3038;
  localparam logic signed [27:0] C_LIN     = -28'sd7357;
  localparam logic signed [63:0] C_OFS     = 64'sd3791;

  // shared divider geometry
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_DEN_W = 20;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T_MUL,
    S_T_X1,
    S_T_DIV,
    S_P_SQ,
    S_P_SQS,
    S_P_X2,
    S_P_X1,
    S_P_B3,
    S_P_X3,
    S_P_B4,
    S_P_B7,
    S_P_DIV,
    S_P_WAIT,
    S_P_C1,
    S_P_C2,
    S_P_C3,
    S_P_C4,
    S_OUT
  } bpc_state_e;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } bpc_div_sts_t;

  // clamp to 24-bit signed, error bit on top
  function automatic logic [24:0] sat24(input logic signed [63:0] v);
    logic [24:0] r;
    if (v > 64'(VAL_MAX)) begin
      r = {1'b1, VAL_MAX};
    end else if (v < 64'(VAL_MIN)) begin
      r = {1'b1, VAL_MIN};
    end else begin
      r = {1'b0, v[23:0]};
    end
    return r;
  endfunction

endpackage

[src/bpc_if.sv]
// Valid/ready channel interfaces for raw readings and compensated results.
// Depends on nothing.
`timescale 1ns / 1ps

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [23:0] raw_reading;

  modport source (output valid, output command, output raw_reading, input ready);
  modport sink   (input valid, input command, input raw_reading, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [23:0] comp_value;
  logic               error_flag;
  logic               no_temp_yet;

  modport source (output valid, output kind, output comp_value, output error_flag,
                  output no_temp_yet, input ready);
  modport sink   (input valid, input kind, input comp_value, input error_flag,
                  input no_temp_yet, output ready);
endinterface

[src/bpc_div.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_div
  import bpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] dividend_i,
  input  logic [DIV_DEN_W-1:0] divisor_i,
  output bpc_div_sts_t         sts_o,
  output logic [DIV_NUM_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q, dvs_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] trial;

  // shift in next dividend bit and try a subtract
  assign rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[DIV_DEN_W+1]) begin
        rem_q <= trial[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_DEN_W-1:0];
        quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

[src/barometer_temp_pressure_compensation.sv]
// Top level of the barometer temperature / pressure compensation block.
// Depends on bpc_pkg, bpc_if (bpc_in_if, bpc_out_if) and bpc_div.
`timescale 1ns / 1ps

//  channel   dir  handshake      word
//  in_i      in   valid/ready    command, raw_reading
//  out_o     out  valid/ready    kind, comp_value, error_flag, no_temp_yet
//  cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// A temperature word and a pressure word both use the 34-step shared
// divider, skipped on a zero divisor, and the shared 44x28 multiplier.
// Ready returns when the result is loaded into the output register. One
// word is in flight; ready is high only while idle.
// The result sits in an output register until taken; a new word is accepted
// while it waits. Reset clears B5 and the seen flag at once, no clearing pass.

module barometer_temp_pressure_compensation
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_in_if.sink      in_i,
  bpc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  bpc_state_e state_q, state_d;

  // configuration
  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAL_A: cal_a_q <= cfg_data_i;
        REG_CAL_B: cal_b_q <= cfg_data_i;
        REG_CAL_C: cal_c_q <= cfg_data_i[31:0];
        REG_OSS:   oss_q   <= cfg_data_i[1:0];
        default:   ;
      endcase
    end
  end

  // calibration fields
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = cal_a_q[63:48];
  assign ac2 = cal_a_q[47:32];
  assign ac3 = cal_a_q[31:16];
  assign ac4 = cal_a_q[15:0];
  assign ac5 = cal_b_q[63:48];
  assign ac6 = cal_b_q[47:32];
  assign b1  = cal_b_q[31:16];
  assign b2  = cal_b_q[15:0];
  assign mc  = cal_c_q[31:16];
  assign md  = cal_c_q[15:0];

  // working registers
  logic               kind_q, early_q, err_q, seen_q, tneg_q, dbl_q, ov_q;
  logic [15:0]        ut_q;
  logic [23:0]        up_q;
  logic signed [27:0] b6_q;
  logic signed [19:0] tx1_q;
  logic signed [42:0] sq_q;
  logic signed [63:0] acc_q, x3a_q, x2f_q;
  logic [31:0]        b3_q, xq_q;
  logic [16:0]        b4_q;
  logic [33:0]        p_q;
  logic signed [31:0] b5_q;
  logic signed [23:0] val_q;
  logic signed [71:0] mul_q;

  logic accept;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // shared multiplier operand select
  logic signed [43:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [16:0] tdiff;
  logic [31:0]        b7diff;
  logic [16:0]        scale;
  assign tdiff  = 17'({1'b0, ut_q}) - 17'({1'b0, ac6});
  assign b7diff = {8'd0, up_q} - b3_q;
  assign scale  = PRS_SCALE >> oss_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_T_MUL: begin
        mul_a = 44'(tdiff);
        mul_b = $signed({12'd0, ac5});
      end
      S_P_SQ: begin
        mul_a = 44'(b6_q);
        mul_b = b6_q;
      end
      S_P_SQS: begin
        mul_a = 44'(b6_q);
        mul_b = 28'(ac2);
      end
      S_P_X2: begin
        mul_a = 44'(sq_q);
        mul_b = 28'(b2);
      end
      S_P_X1: begin
        mul_a = 44'(b6_q);
        mul_b = 28'(ac3);
      end
      S_P_B3: begin
        mul_a = 44'(sq_q);
        mul_b = 28'(b1);
      end
      S_P_B4: begin
        mul_a = $signed({12'd0, xq_q});
        mul_b = $signed({12'd0, ac4});
      end
      S_P_B7: begin
        mul_a = $signed({12'd0, b7diff});
        mul_b = $signed({11'd0, scale});
      end
      S_P_C1: begin
        mul_a = $signed({10'd0, p_q});
        mul_b = C_LIN;
      end
      S_P_C2: begin
        mul_a = $signed({18'd0, p_q[33:8]});
        mul_b = C_SQ;
      end
      S_P_C3: begin
        mul_a = mul_q[43:0];
        mul_b = $signed({2'd0, p_q[33:8]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // temperature divisor and dividend
  logic signed [19:0] tx1_c, tdiv;
  logic signed [26:0] mcs;
  logic [26:0]        mc_abs;
  logic [19:0]        tdiv_abs;
  assign tx1_c    = 20'(mul_q >>> 15);
  assign tdiv     = tx1_c + 20'(md);
  assign mcs      = {mc, 11'd0};
  assign mc_abs   = mcs[26] ? 27'(-mcs) : 27'(mcs);
  assign tdiv_abs = tdiv[19] ? 20'(-tdiv) : 20'(tdiv);

  // shared divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  bpc_div_sts_t         div_sts;
  logic [31:0]          b7;
  assign b7 = mul_q[31:0];

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == S_T_X1) begin
      div_start = (tdiv != '0);
      div_num   = {7'd0, mc_abs};
      div_den   = tdiv_abs;
    end else if (state_q == S_P_DIV) begin
      div_start = (b4_q != '0);
      div_num   = b7[31] ? {2'b00, b7} : {1'b0, b7, 1'b0};
      div_den   = {3'd0, b4_q};
    end
  end

  bpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .sts_o      (div_sts),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = (in_i.command == CMD_PRES) ? S_P_SQ : S_T_MUL;
      S_T_MUL:  state_d = S_T_X1;
      S_T_X1:   state_d = (tdiv == '0) ? S_OUT : S_T_DIV;
      S_T_DIV:  if (div_sts.done) state_d = S_OUT;
      S_P_SQ:   state_d = S_P_SQS;
      S_P_SQS:  state_d = S_P_X2;
      S_P_X2:   state_d = S_P_X1;
      S_P_X1:   state_d = S_P_B3;
      S_P_B3:   state_d = S_P_X3;
      S_P_X3:   state_d = S_P_B4;
      S_P_B4:   state_d = S_P_B7;
      S_P_B7:   state_d = S_P_DIV;
      S_P_DIV:  state_d = (b4_q == '0) ? S_OUT : S_P_WAIT;
      S_P_WAIT: if (div_sts.done) state_d = S_P_C1;
      S_P_C1:   state_d = S_P_C2;
      S_P_C2:   state_d = S_P_C3;
      S_P_C3:   state_d = S_P_C4;
      S_P_C4:   state_d = S_OUT;
      S_OUT:    if (!ov_q || out_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // combinational pieces of the datapath steps
  logic signed [31:0] tq, b5_c;
  logic [24:0]        tsat, psat;
  logic signed [63:0] t_sh, t2, b3_c, x3_c, pf_c;
  assign tq   = tneg_q ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
  assign b5_c = 32'(tx1_q) + tq;
  assign tsat = sat24(64'((b5_c + 32'sd8) >>> 4));
  assign t_sh = acc_q <<< oss_q;
  assign t2   = t_sh + 64'sd2;
  assign b3_c = t2[63] ? -((-t2) >>> 2) : (t2 >>> 2);
  assign x3_c = (x3a_q + 64'(mul_q >>> 16) + 64'sd2) >>> 2;
  assign pf_c = $signed({30'd0, p_q}) + ((64'(mul_q >>> 16) + x2f_q + C_OFS) >>> 4);
  assign psat = sat24(pf_c);

  // kept intermediate and seen flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_q   <= '0;
      seen_q <= 1'b0;
    end else if (state_q == S_T_DIV && div_sts.done) begin
      b5_q   <= b5_c;
      seen_q <= 1'b1;
    end
  end

  // step registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_q  <= in_i.command;
          ut_q    <= in_i.raw_reading[15:0];
          up_q    <= in_i.raw_reading >> (4'd8 - {2'b00, oss_q});
          b6_q    <= 28'(b5_q) - B6_OFS;
          early_q <= (in_i.command == CMD_PRES) && !seen_q;
          err_q   <= 1'b0;
        end
      end
      S_T_X1: begin
        tx1_q  <= tx1_c;
        tneg_q <= mc[15] ^ tdiv[19];
        if (tdiv == '0) begin
          err_q <= 1'b1;
          val_q <= mc[15] ? VAL_MIN : VAL_MAX;
        end
      end
      S_T_DIV: begin
        if (div_sts.done) begin
          err_q <= tsat[24];
          val_q <= tsat[23:0];
        end
      end
      S_P_SQS: sq_q  <= 43'(mul_q >>> 12);
      S_P_X2:  acc_q <= (64'(ac1) <<< 2) + 64'(mul_q >>> 11);
      S_P_X1:  acc_q <= acc_q + 64'(mul_q >>> 11);
      S_P_B3: begin
        b3_q  <= b3_c[31:0];
        x3a_q <= 64'(mul_q >>> 13);
      end
      S_P_X3:  xq_q <= 32'(x3_c + X3_OFS);
      S_P_B7:  b4_q <= mul_q[31:15];
      S_P_DIV: begin
        dbl_q <= b7[31];
        if (b4_q == '0) begin
          err_q <= 1'b1;
          val_q <= VAL_MAX;
        end
      end
      S_P_WAIT: begin
        if (div_sts.done) p_q <= dbl_q ? {div_quo[32:0], 1'b0} : div_quo;
      end
      S_P_C2:  x2f_q <= 64'(mul_q >>> 16);
      S_P_C4: begin
        err_q <= psat[24];
        val_q <= psat[23:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (state_q == S_OUT && (!ov_q || out_o.ready)) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  logic               o_kind_q, o_err_q, o_early_q;
  logic signed [23:0] o_val_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!ov_q || out_o.ready)) begin
      o_kind_q  <= kind_q;
      o_val_q   <= val_q;
      o_err_q   <= err_q;
      o_early_q <= early_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.kind        = o_kind_q;
  assign out_o.comp_value  = o_val_q;
  assign out_o.error_flag  = o_err_q;
  assign out_o.no_temp_yet = o_early_q;

  // checks
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_err_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_flag |->
      (out_o.comp_value == VAL_MAX) || (out_o.comp_value == VAL_MIN))
    else $error("error flag without a saturated value");

  a_early_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.no_temp_yet |-> out_o.kind == CMD_PRES)
    else $error("no-temperature flag on a temperature result");

  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |=> seen_q)
    else $error("temperature seen flag dropped");

endmodule

[sim/tb_top.sv]
// Testbench for barometer_temp_pressure_compensation: directed and random raw
// readings checked against a built-in compensation predictor.
// Depends on bpc_pkg, bpc_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top
  import bpc_pkg::*;
();

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE      = 80;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] value;
    logic               err;
    logic               early;
  } comp_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();

  barometer_temp_pressure_compensation u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // predictor copy of the registers and kept state
  logic [63:0]        cal_a, cal_b, cal_c;
  logic [1:0]         oss_set;
  logic signed [31:0] b5_kept;
  logic               temp_seen;

  comp_word_t expected_q[$];
  int         fail_cnt = 0;
  int         cycles = 0;
  int         burst_left;
  int         stall_mode = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // integer compensation scheme, updates the kept B5 on a good temperature
  function automatic comp_word_t compensate(logic cmd, logic [23:0] raw);
    comp_word_t  r;
    longint      ut, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    longint      x1, x2, x3, dv, b5, v, b6, sq, t, b3, p, q;
    int unsigned ac4, up, b4, b7;
    int unsigned sh;
    r.kind  = cmd;
    r.err   = 1'b0;
    r.early = 1'b0;
    if (cmd == CMD_TEMP) begin
      ut  = raw[15:0];
      ac5 = cal_b[63:48];
      ac6 = cal_b[47:32];
      mc  = longint'($signed(cal_c[31:16]));
      md  = longint'($signed(cal_c[15:0]));
      x1  = ((ut - ac6) * ac5) >>> 15;
      dv  = x1 + md;
      if (dv == 0) begin
        r.err = 1'b1;
        v = (mc >= 0) ? 64'sd8388607 : -64'sd8388608;
      end else begin
        b5 = x1 + (mc * 2048) / dv;
        b5_kept   = b5[31:0];
        temp_seen = 1'b1;
        v = (longint'(b5_kept) + 8) >>> 4;
      end
    end else begin
      sh  = oss_set;
      ac1 = longint'($signed(cal_a[63:48]));
      ac2 = longint'($signed(cal_a[47:32]));
      ac3 = longint'($signed(cal_a[31:16]));
      ac4 = cal_a[15:0];
      b1  = longint'($signed(cal_b[31:16]));
      b2  = longint'($signed(cal_b[15:0]));
      up  = raw >> (8 - sh);
      b6  = longint'(b5_kept) - 4000;
      sq  = (b6 * b6) >>> 12;
      x1  = (b2 * sq) >>> 11;
      x2  = (ac2 * b6) >>> 11;
      t   = (ac1 * 4 + x1 + x2) << sh;
      b3  = (t + 2) / 4;
      r.early = !temp_seen;
      x1  = (ac3 * b6) >>> 13;
      x2  = (b1 * sq) >>> 16;
      x3  = (x1 + x2 + 2) >>> 2;
      b4  = (ac4 * 32'(x3 + 32768)) >> 15;
      b7  = (up - 32'(b3)) * (32'd50000 >> sh);
      if (b4 == 0) begin
        r.err = 1'b1;
        v = 64'sd8388607;
      end else begin
        if (b7 < 32'h8000_0000) p = (longint'(b7) * 2) / longint'(b4);
        else p = longint'(b7 / b4) * 2;
        q  = p >>> 8;
        x1 = (q * q * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        v  = p + ((x1 + x2 + 3791) >>> 4);
      end
    end
    // saturate to 24 bits
    if (v > 64'sd8388607) begin
      r.err = 1'b1;
      v = 64'sd8388607;
    end else if (v < -64'sd8388608) begin
      r.err = 1'b1;
      v = -64'sd8388608;
    end
    r.value = v[23:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    comp_word_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.comp_value, out_if.error_flag, out_if.no_temp_yet};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word kind=%0b value=%0d err=%0b early=%0b", $time,
                 got.kind, got.value, got.err, got.early);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.err !== want.err || got.early !== want.early) begin
          $display("%0t: mismatch expected kind=%0b value=%0d err=%0b early=%0b",
                   $time, want.kind, want.value, want.err, want.early);
          $display("%0t:          actual   kind=%0b value=%0d err=%0b early=%0b",
                   $time, got.kind, got.value, got.err, got.early);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall pattern: the mode is redrawn periodically from four patterns
  always @(negedge clk) begin
    if (cycles % 150 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_if.ready = 1'b1;
      1: out_if.ready = ($urandom_range(0, 1) == 0);
      2: out_if.ready = ($urandom_range(0, 5) == 0);
      default: out_if.ready = ((cycles % 7) < 3);
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // one word into the block; valid stays high inside a burst
  task automatic send_reading(logic cmd, logic [23:0] raw);
    in_if.valid       = 1'b1;
    in_if.command     = cmd;
    in_if.raw_reading = raw;
    do @(posedge clk); while (!in_if.ready);
    expected_q.push_back(compensate(cmd, raw));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // sender pause until every result has come, then settle
  task automatic drain();
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    drain();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CAL_A: cal_a = data;
      REG_CAL_B: cal_b = data;
      REG_CAL_C: cal_c = {16'd0, data[47:0]};
      default:   oss_set = data[1:0];
    endcase
  endtask

  // typical calibration with some jitter
  task automatic load_typical_cal();
    write_reg(REG_CAL_A, {16'(408 + $urandom_range(0, 64) - 32), 16'(-72),
                          16'(-14383 + $urandom_range(0, 200)),
                          16'(32741 - $urandom_range(0, 500))});
    write_reg(REG_CAL_B, {16'(32757 - $urandom_range(0, 900)), 16'(23153),
                          16'(6190), 16'(4)});
    write_reg(REG_CAL_C, {16'($urandom), 16'(-32768),
                          16'(-8711 + $urandom_range(0, 100)), 16'(2868)});
  endtask

  task automatic test_pressure_before_temp();
    // reset calibration gives a zero pressure divisor too
    send_reading(CMD_PRES, 24'h5D2300);
    load_typical_cal();
    send_reading(CMD_PRES, 24'h000000);
    send_reading(CMD_PRES, 24'hFFFFFF);
  endtask

  task automatic test_directed();
    int o;
    for (o = 0; o < 4; o++) begin
      write_reg(REG_OSS, 64'(o));
      send_reading(CMD_TEMP, 24'h006CFA);
      send_reading(CMD_PRES, 24'h5D2300);
      send_reading(CMD_TEMP, 24'hFF0000);
      send_reading(CMD_PRES, 24'hFFFFFF);
      send_reading(CMD_TEMP, 24'hFFFFFF);
      send_reading(CMD_PRES, 24'h000000);
    end
  endtask

  task automatic test_extreme_cal();
    write_reg(REG_CAL_A, {64{1'b1}});
    write_reg(REG_CAL_B, {64{1'b1}});
    write_reg(REG_CAL_C, {64{1'b1}});
    send_reading(CMD_TEMP, 24'h000000);
    send_reading(CMD_PRES, 24'hABCDEF);
    write_reg(REG_CAL_A, 64'h8000_8000_8000_8000);
    write_reg(REG_CAL_B, 64'h8000_8000_8000_8000);
    write_reg(REG_CAL_C, 64'h8000_8000_8000);
    send_reading(CMD_TEMP, 24'h00FFFF);
    send_reading(CMD_PRES, 24'h800000);
  endtask

  task automatic test_zero_divisors();
    // ac5 = 0 and md = 0 make the temperature divisor zero, both mc signs
    write_reg(REG_CAL_B, 64'h0000_5A71_182E_0004);
    write_reg(REG_CAL_C, 64'h0000_8000_21E9_0000);
    send_reading(CMD_TEMP, 24'h1234AB);
    write_reg(REG_CAL_C, 64'h0000_8000_DDE9_0000);
    send_reading(CMD_TEMP, 24'h006CFA);
    // ac4 = 0 makes the pressure divisor zero
    write_reg(REG_CAL_A, 64'h0198_FFB8_C7D1_0000);
    send_reading(CMD_PRES, 24'h5D2300);
  endtask

  task automatic test_random(int n_phases, int per_phase);
    int ph, i;
    for (ph = 0; ph < n_phases; ph++) begin
      write_reg(REG_OSS, 64'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_CAL_A, {$urandom, $urandom});
        write_reg(REG_CAL_B, {$urandom, $urandom});
        write_reg(REG_CAL_C, {$urandom, $urandom});
      end else begin
        load_typical_cal();
      end
      for (i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2) drain();
        case ($urandom_range(0, 9))
          0, 1, 2: send_reading(CMD_TEMP, {8'($urandom),
                                           16'($urandom_range(19000, 36000))});
          3:       send_reading(1'($urandom), 24'($urandom));
          default: send_reading(CMD_PRES, 24'($urandom_range(24'h300000, 24'hA00000)));
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_CAL_A;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_TEMP;
    in_if.raw_reading = '0;
    cal_a = '0;
    cal_b = '0;
    cal_c = '0;
    oss_set = 2'd1;
    b5_kept = '0;
    temp_seen = 1'b0;
    burst_left = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_pressure_before_temp();
    test_directed();
    test_extreme_cal();
    test_zero_divisors();
    test_random(10, 105);

    drain();
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
